// ===== design/mbm_pkg.sv =====
// shared types, codes and crc helper for the modbus meter request/reply block
// no dependencies; imported by mbm_reply, mbm_tx and modbus_meter_request_and_reply
package mbm_pkg;

    localparam int LEN_W            = 7;
    localparam int MAX_REPLY_BYTES  = 64;
    localparam logic [LEN_W-1:0] REPLY_LENGTH_RESET = 7'd25;
    localparam logic [LEN_W-1:0] MAX_LEN = 7'(MAX_REPLY_BYTES);

    localparam logic [7:0]  SLAVE_ADDR      = 8'hf8;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [15:0] CRC_INIT        = 16'hffff;
    localparam logic [15:0] CRC_POLY        = 16'ha001;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_REPLY   = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_TX      = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_CRC   = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] voltage;
        logic [31:0] current;
        logic [31:0] power;
        logic [15:0] frequency;
    } t_verdict;

    // crc-16/modbus, one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // crc after the fixed slave and function bytes
    localparam logic [15:0] CRC_SEED = crc_byte(crc_byte(CRC_INIT, SLAVE_ADDR), FUNC_READ_INPUT);

    // crc fold position: bytes 2..5 of the frame, done when it reaches 6
    localparam logic [2:0] CPOS_FIRST = 3'd2;
    localparam logic [2:0] CPOS_DONE  = 3'd6;
    localparam logic [2:0] IDX_LAST   = 3'd7;

endpackage

// ===== design/mbm_reply.sv =====
// reply side: running crc, byte count and measurement stores, plus the verdict
// depends on mbm_pkg
module mbm_reply
    import mbm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_byte_en,
    input  logic [7:0]       i_byte,
    input  logic             i_clear,
    input  logic [LEN_W-1:0] i_len,
    output t_verdict         o_verdict
);

    logic [15:0]      r_crc;
    logic [LEN_W-1:0] r_count;
    logic [15:0]      r_voltage;
    logic [31:0]      r_current;
    logic [31:0]      r_power;
    logic [15:0]      r_frequency;

    logic take;
    assign take = i_byte_en && (r_count < i_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_crc       <= CRC_INIT;
            r_count     <= '0;
            r_voltage   <= '0;
            r_current   <= '0;
            r_power     <= '0;
            r_frequency <= '0;
        end else if (take) begin
            r_crc   <= crc_byte(r_crc, i_byte);
            r_count <= r_count + 1'b1;
            // fixed byte offsets in the reply; 32-bit words come low word first
            case (r_count)
                7'd3:    r_voltage[15:8]    <= i_byte;
                7'd4:    r_voltage[7:0]     <= i_byte;
                7'd5:    r_current[15:8]    <= i_byte;
                7'd6:    r_current[7:0]     <= i_byte;
                7'd7:    r_current[31:24]   <= i_byte;
                7'd8:    r_current[23:16]   <= i_byte;
                7'd9:    r_power[15:8]      <= i_byte;
                7'd10:   r_power[7:0]       <= i_byte;
                7'd11:   r_power[31:24]     <= i_byte;
                7'd12:   r_power[23:16]     <= i_byte;
                7'd17:   r_frequency[15:8]  <= i_byte;
                7'd18:   r_frequency[7:0]   <= i_byte;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_verdict = '0;
        if (r_count < i_len) begin
            o_verdict.status = ST_SHORT;
        end else if ((i_len >= 7'd2) && (r_crc != 16'h0000)) begin
            // residue over the whole frame including the crc bytes
            o_verdict.status = ST_CRC;
        end else begin
            o_verdict.status    = ST_OK;
            o_verdict.voltage   = r_voltage;
            o_verdict.current   = r_current;
            o_verdict.power     = r_power;
            o_verdict.frequency = r_frequency;
        end
    end

endmodule

// ===== design/mbm_tx.sv =====
// result register: serializes the 8-byte request frame or holds one verdict beat
// folds the request crc one byte per cycle; depends on mbm_pkg
module mbm_tx
    import mbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load_frame,
    input  logic        i_load_verdict,
    input  logic [15:0] i_addr,
    input  logic [15:0] i_count,
    input  t_verdict    i_verdict,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output t_kind       o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output t_verdict    o_verdict
);

    logic        r_busy;
    logic [2:0]  r_idx;
    logic [2:0]  r_cpos;
    t_kind       r_kind;
    logic [15:0] r_addr;
    logic [15:0] r_count;
    logic [15:0] r_crc;
    t_verdict    r_verdict;

    logic       last_beat;
    logic       pop;
    logic [7:0] fold_byte;

    assign last_beat = (r_kind == KIND_VERDICT) || (r_idx == IDX_LAST);
    assign pop       = r_busy && i_ready;
    assign o_free    = !r_busy || (pop && last_beat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_cpos <= CPOS_DONE;
        end else begin
            if (i_load_frame || i_load_verdict) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (pop) begin
                if (last_beat) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_load_frame) begin
                r_cpos <= CPOS_FIRST;
            end else if (r_cpos != CPOS_DONE) begin
                r_cpos <= r_cpos + 1'b1;
            end
        end
    end

    // the fold runs over bytes 2 to 5 and finishes before beat 6 can be shown
    always_comb begin
        case (r_cpos)
            3'd2:    fold_byte = r_addr[15:8];
            3'd3:    fold_byte = r_addr[7:0];
            3'd4:    fold_byte = r_count[15:8];
            3'd5:    fold_byte = r_count[7:0];
            default: fold_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load_frame) begin
            r_kind    <= KIND_TX;
            r_addr    <= i_addr;
            r_count   <= i_count;
            r_crc     <= CRC_SEED;
            r_verdict <= '0;
        end else begin
            if (i_load_verdict) begin
                r_kind    <= KIND_VERDICT;
                r_verdict <= i_verdict;
            end
            if (r_cpos != CPOS_DONE) begin
                r_crc <= crc_byte(r_crc, fold_byte);
            end
        end
    end

    always_comb begin
        o_tx_byte = 8'h00;
        if (r_kind == KIND_TX) begin
            case (r_idx)
                3'd0:    o_tx_byte = SLAVE_ADDR;
                3'd1:    o_tx_byte = FUNC_READ_INPUT;
                3'd2:    o_tx_byte = r_addr[15:8];
                3'd3:    o_tx_byte = r_addr[7:0];
                3'd4:    o_tx_byte = r_count[15:8];
                3'd5:    o_tx_byte = r_count[7:0];
                3'd6:    o_tx_byte = r_crc[7:0];
                3'd7:    o_tx_byte = r_crc[15:8];
                default: o_tx_byte = 8'h00;
            endcase
        end
    end

    assign o_valid   = r_busy;
    assign o_kind    = r_kind;
    assign o_last    = (r_kind == KIND_TX) && (r_idx == IDX_LAST);
    assign o_verdict = r_verdict;

endmodule

// ===== design/modbus_meter_request_and_reply.sv =====
// Modbus RTU read-input-registers master for a power meter, top level
// Input beats: request (opcode 0) or reply (opcode 1); a reply beat with rx_end
// set closes the reply. Output beats: 8 request frame bytes, or one verdict.
// Reply bytes produce no output and are taken every cycle, even while the
// output register is busy. A request or end-of-reply beat is taken when the
// output register is empty or its last beat is taken in the same cycle.
// The first output beat appears in the cycle after the input beat is taken.
// Throughput: one reply byte per cycle; a request occupies the output for 8
// beats, a verdict for 1, set by the single output register.
// The request crc is folded one byte per cycle behind that register.
// Reply length is written through i_cfg_we/i_cfg_data; the user must write it only
// while the block is idle, the block does not enforce this; lengths above 64 act as 64.
// Reset (synchronous, active low) empties the output, sets reply length to 25
// and clears the running crc, byte count and measurement stores.
// When the receiver stalls the current output beat holds unchanged.
// depends on mbm_pkg, mbm_reply, mbm_tx
module modbus_meter_request_and_reply
    import mbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_register_address,
    input  logic [15:0] i_register_count,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic [1:0]  o_status,
    output logic [15:0] o_voltage_tenths,
    output logic [31:0] o_current_milliamps,
    output logic [31:0] o_power_tenths,
    output logic [15:0] o_frequency_tenths
);

    logic [LEN_W-1:0] r_reply_length;
    logic [LEN_W-1:0] eff_len;

    logic     is_request;
    logic     is_byte;
    logic     is_end;
    logic     accept;
    logic     tx_free;
    t_kind    out_kind;
    t_verdict reply_verdict;
    t_verdict out_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_length <= REPLY_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_reply_length <= i_cfg_data;
        end
    end

    assign eff_len = (r_reply_length > MAX_LEN) ? MAX_LEN : r_reply_length;

    assign is_request = (i_opcode == OP_REQUEST);
    assign is_byte    = (i_opcode == OP_REPLY) && !i_rx_end;
    assign is_end     = (i_opcode == OP_REPLY) && i_rx_end;

    // plain reply bytes never need the output register
    assign o_in_ready = is_byte || tx_free;
    assign accept     = i_in_valid && o_in_ready;

    mbm_reply u_reply (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (accept && is_byte),
        .i_byte    (i_rx_byte),
        .i_clear   (accept && !is_byte),
        .i_len     (eff_len),
        .o_verdict (reply_verdict)
    );

    mbm_tx u_tx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load_frame   (accept && is_request),
        .i_load_verdict (accept && is_end),
        .i_addr         (i_register_address),
        .i_count        (i_register_count),
        .i_verdict      (reply_verdict),
        .o_free         (tx_free),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_kind         (out_kind),
        .o_tx_byte      (o_tx_byte),
        .o_last         (o_last),
        .o_verdict      (out_verdict)
    );

    assign o_kind              = out_kind;
    assign o_status            = out_verdict.status;
    assign o_voltage_tenths    = out_verdict.voltage;
    assign o_current_milliamps = out_verdict.current;
    assign o_power_tenths      = out_verdict.power;
    assign o_frequency_tenths  = out_verdict.frequency;

`ifndef SYNTHESIS
    a_request_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == OP_REQUEST)) |=>
        (o_out_valid && (o_kind == KIND_TX) && (o_tx_byte == SLAVE_ADDR) && !o_last))
        else $error("request beat did not start a frame");

    a_end_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == OP_REPLY) && i_rx_end) |=>
        (o_out_valid && (o_kind == KIND_VERDICT) && !o_last))
        else $error("end-of-reply beat did not give a verdict");

    a_bad_verdict_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_VERDICT) && (o_status != ST_OK)) |->
        ((o_voltage_tenths == 16'h0) && (o_current_milliamps == 32'h0) &&
         (o_power_tenths == 32'h0) && (o_frequency_tenths == 16'h0)))
        else $error("failed verdict carries measurements");
`endif

endmodule

// ===== sim/mbm_meter_checker.sv =====
// crc helper and the checking side of the modbus meter testbench
// mbm_meter_checker watches the request and reply channels, keeps its own copy of the
// block's state and compares every output beat; depends on mbm_pkg
package mbm_check_pkg;

    import mbm_pkg::*;

    // crc-16/modbus, one byte, lsb first
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

endpackage

module mbm_meter_checker
    import mbm_pkg::*;
    import mbm_check_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_register_address,
    input  logic [15:0] i_register_count,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_last,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_voltage_tenths,
    input  logic [31:0] i_current_milliamps,
    input  logic [31:0] i_power_tenths,
    input  logic [15:0] i_frequency_tenths,
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic        last;
        t_status     status;
        logic [15:0] voltage;
        logic [31:0] current;
        logic [31:0] power;
        logic [15:0] frequency;
    } t_meter_beat;

    t_meter_beat expected_beats[$];

    logic [6:0]  reply_len_q;
    logic [15:0] reply_crc;
    logic [6:0]  reply_count;
    logic [15:0] volts;
    logic [31:0] amps;
    logic [31:0] watts;
    logic [15:0] hertz;

    function automatic logic [6:0] effective_length();
        return (reply_len_q > MAX_LEN) ? MAX_LEN : reply_len_q;
    endfunction

    task automatic clear_reply();
        reply_crc   = CRC_INIT;
        reply_count = '0;
        volts       = '0;
        amps        = '0;
        watts       = '0;
        hertz       = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic push_request_frame(input logic [15:0] addr, input logic [15:0] cnt);
        logic [7:0]  frame [8];
        logic [15:0] crc;
        t_meter_beat b;
        frame[0] = SLAVE_ADDR;
        frame[1] = FUNC_READ_INPUT;
        frame[2] = addr[15:8];
        frame[3] = addr[7:0];
        frame[4] = cnt[15:8];
        frame[5] = cnt[7:0];
        crc = CRC_INIT;
        for (int k = 0; k < 6; k++) begin
            crc = crc16_fold(crc, frame[k]);
        end
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        for (int k = 0; k < 8; k++) begin
            b = '0;
            b.kind = KIND_TX;
            b.tx_byte = frame[k];
            b.last = (k == 7);
            expected_beats.push_back(b);
        end
        clear_reply();
    endtask

    task automatic take_reply_byte(input logic [7:0] b);
        // bytes past the expected length leave no trace
        if (reply_count < effective_length()) begin
            reply_crc = crc16_fold(reply_crc, b);
            case (reply_count)
                7'd3:  volts[15:8]  = b;
                7'd4:  volts[7:0]   = b;
                7'd5:  amps[15:8]   = b;
                7'd6:  amps[7:0]    = b;
                7'd7:  amps[31:24]  = b;
                7'd8:  amps[23:16]  = b;
                7'd9:  watts[15:8]  = b;
                7'd10: watts[7:0]   = b;
                7'd11: watts[31:24] = b;
                7'd12: watts[23:16] = b;
                7'd17: hertz[15:8]  = b;
                7'd18: hertz[7:0]   = b;
                default: ;
            endcase
            reply_count++;
        end
    endtask

    task automatic push_verdict();
        t_meter_beat b;
        logic [6:0]  eff;
        eff = effective_length();
        b = '0;
        b.kind = KIND_VERDICT;
        if (reply_count < eff) begin
            b.status = ST_SHORT;
        end else if (eff >= 7'd2 && reply_crc != 16'h0000) begin
            // residue over data plus crc bytes is zero for a good frame
            b.status = ST_CRC;
        end else begin
            b.status    = ST_OK;
            b.voltage   = volts;
            b.current   = amps;
            b.power     = watts;
            b.frequency = hertz;
        end
        expected_beats.push_back(b);
        clear_reply();
    endtask

    task automatic check_beat();
        t_meter_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected, kind", {31'b0, i_kind}, 32'h0);
        end else begin
            want = expected_beats.pop_front();
            if (i_kind !== want.kind)
                report_mismatch("kind", {31'b0, i_kind}, {31'b0, want.kind});
            if (i_tx_byte !== want.tx_byte)
                report_mismatch("tx_byte", {24'b0, i_tx_byte}, {24'b0, want.tx_byte});
            if (i_last !== want.last)
                report_mismatch("last", {31'b0, i_last}, {31'b0, want.last});
            if (i_status !== want.status)
                report_mismatch("status", {30'b0, i_status}, {30'b0, want.status});
            if (i_voltage_tenths !== want.voltage)
                report_mismatch("voltage", {16'b0, i_voltage_tenths}, {16'b0, want.voltage});
            if (i_current_milliamps !== want.current)
                report_mismatch("current", i_current_milliamps, want.current);
            if (i_power_tenths !== want.power)
                report_mismatch("power", i_power_tenths, want.power);
            if (i_frequency_tenths !== want.frequency)
                report_mismatch("frequency", {16'b0, i_frequency_tenths},
                                {16'b0, want.frequency});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reply_len_q = REPLY_LENGTH_RESET;
            clear_reply();
            expected_beats.delete();
        end else begin
            // an output beat can never belong to an input taken at the same edge
            if (i_out_valid && i_out_ready) begin
                check_beat();
            end
            if (i_cfg_we) begin
                reply_len_q = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_opcode == OP_REQUEST) begin
                    push_request_frame(i_register_address, i_register_count);
                end else if (i_rx_end) begin
                    push_verdict();
                end else begin
                    take_reply_byte(i_rx_byte);
                end
            end
        end
        o_outstanding = expected_beats.size();
    end

endmodule

// ===== sim/modbus_meter_request_and_reply_test.sv =====
// testbench top for modbus_meter_request_and_reply: clock, reset, request and reply
// stimulus with random idling, final verdict; depends on mbm_pkg, mbm_check_pkg,
// mbm_meter_checker and the block itself
module modbus_meter_request_and_reply_test;

    import mbm_pkg::*;
    import mbm_check_pkg::*;

    typedef enum int {
        RP_CLEAN,
        RP_CORRUPT,
        RP_SHORT,
        RP_EXCESS,
        RP_NOISE
    } t_reply_shape;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_cfg_we           = 1'b0;
    logic [6:0]  i_cfg_data         = '0;
    logic        i_in_valid         = 1'b0;
    logic        i_opcode           = 1'b0;
    logic [15:0] i_register_address = '0;
    logic [15:0] i_register_count   = '0;
    logic [7:0]  i_rx_byte          = '0;
    logic        i_rx_end           = 1'b0;
    logic        i_out_ready        = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic [1:0]  o_status;
    logic [15:0] o_voltage_tenths;
    logic [31:0] o_current_milliamps;
    logic [31:0] o_power_tenths;
    logic [15:0] o_frequency_tenths;

    int fail_count;
    int beats_pending;
    int items_sent = 0;
    int cur_len    = REPLY_LENGTH_RESET;
    bit no_idle    = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    modbus_meter_request_and_reply i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_register_address (i_register_address),
        .i_register_count   (i_register_count),
        .i_rx_byte          (i_rx_byte),
        .i_rx_end           (i_rx_end),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_tx_byte          (o_tx_byte),
        .o_last             (o_last),
        .o_status           (o_status),
        .o_voltage_tenths   (o_voltage_tenths),
        .o_current_milliamps(o_current_milliamps),
        .o_power_tenths     (o_power_tenths),
        .o_frequency_tenths (o_frequency_tenths)
    );

    mbm_meter_checker i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_register_address (i_register_address),
        .i_register_count   (i_register_count),
        .i_rx_byte          (i_rx_byte),
        .i_rx_end           (i_rx_end),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_kind             (o_kind),
        .i_tx_byte          (o_tx_byte),
        .i_last             (o_last),
        .i_status           (o_status),
        .i_voltage_tenths   (o_voltage_tenths),
        .i_current_milliamps(o_current_milliamps),
        .i_power_tenths     (o_power_tenths),
        .i_frequency_tenths (o_frequency_tenths),
        .o_fail_count       (fail_count),
        .o_outstanding      (beats_pending)
    );

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_length();
        case ($urandom_range(0, 11))
            0:       return 2;
            1:       return 64;
            2:       return 127;   // above the limit, acts as 64
            3:       return 0;
            4:       return 1;
            5:       return 19;
            6:       return 25;
            default: return $urandom_range(2, 30);
        endcase
    endfunction

    // one input beat; valid stays up into the next call when it draws no gap
    task automatic put_item(input t_opcode op, input logic [15:0] addr,
                            input logic [15:0] cnt, input logic [7:0] b, input logic e);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_opcode           <= op;
        i_register_address <= addr;
        i_register_count   <= cnt;
        i_rx_byte          <= b;
        i_rx_end           <= e;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_request(input logic [15:0] addr, input logic [15:0] cnt);
        put_item(OP_REQUEST, addr, cnt, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        put_item(OP_REPLY, 16'($urandom), 16'($urandom), b, 1'b0);
    endtask

    task automatic send_end();
        put_item(OP_REPLY, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
    endtask

    // hold off until every expected beat is out, then let trailing reply bytes drain
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (beats_pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_length(input int len);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 7'(len);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_len = len;
    endtask

    task automatic send_reply(input t_reply_shape shape);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        int          eff;
        int          k;
        eff = (cur_len > MAX_REPLY_BYTES) ? MAX_REPLY_BYTES : cur_len;
        if (shape == RP_NOISE) begin
            // random bytes with the odd request cutting in
            repeat ($urandom_range(0, eff + 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request(pick_word(), pick_word());
                end else begin
                    send_byte(pick_byte());
                end
            end
        end else begin
            crc = CRC_INIT;
            if (eff >= 2) begin
                for (k = 0; k < eff - 2; k++) begin
                    frame.push_back(pick_byte());
                    crc = crc16_fold(crc, frame[k]);
                end
                frame.push_back(crc[7:0]);
                frame.push_back(crc[15:8]);
            end else begin
                repeat (eff) frame.push_back(pick_byte());
            end
            case (shape)
                RP_CORRUPT: begin
                    if (frame.size() != 0) begin
                        k = $urandom_range(0, frame.size() - 1);
                        frame[k] = frame[k] ^ (8'h01 << $urandom_range(0, 7));
                    end
                end
                RP_SHORT: begin
                    if (frame.size() != 0) begin
                        repeat ($urandom_range(1, frame.size())) void'(frame.pop_back());
                    end
                end
                RP_EXCESS: begin
                    repeat ($urandom_range(1, 6)) frame.push_back(pick_byte());
                end
                default: ;
            endcase
            foreach (frame[i]) begin
                send_byte(frame[i]);
            end
        end
        send_end();
    endtask

    // receive side: random stall before each output beat
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    initial begin
        t_reply_shape shape;
        int           pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length: frame extremes, then an end with nothing received
        send_request(16'h0000, 16'h0000);
        send_request(16'hffff, 16'hffff);
        send_end();
        settle();
        // zero length: ok at once, extra bytes ignored
        set_length(0);
        send_end();
        send_byte(8'hff);
        send_end();
        settle();
        // length one: no checksum, byte not at a measurement offset
        set_length(1);
        send_byte(8'h5a);
        send_end();
        settle();
        // length two: crc of nothing, then a bad one
        set_length(2);
        send_byte(8'hff);
        send_byte(8'hff);
        send_end();
        send_byte(8'h00);
        send_byte(8'hff);
        send_end();
        settle();
        set_length(127);
        send_end();
        settle();

        while (items_sent < 260) begin
            set_length(pick_length());
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_request(pick_word(), pick_word());
                end
                pick = $urandom_range(0, 9);
                if (pick < 6) shape = RP_CLEAN;
                else if (pick == 6) shape = RP_CORRUPT;
                else if (pick == 7) shape = RP_SHORT;
                else if (pick == 8) shape = RP_EXCESS;
                else shape = RP_NOISE;
                send_reply(shape);
            end
            settle();
        end

        no_idle = 1'b0;
        settle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/mbm_pkg.sv
design/mbm_reply.sv
design/mbm_tx.sv
design/modbus_meter_request_and_reply.sv
sim/mbm_meter_checker.sv
sim/modbus_meter_request_and_reply_test.sv
